// ----- src/tpps_pkg.sv -----
// Package for the Thumb push/pop sequencer: shared types, constants and
// bit-search helpers. No dependencies.
package tpps_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned ListW = 8;
  localparam int unsigned SelW = 3;
  localparam int unsigned CountW = 4;
  localparam int unsigned RegW = 4;

  localparam logic [AddrW-1:0] WordBytes = 32'd4;
  localparam logic [RegW-1:0] RegLr = 4'd14;
  localparam logic [RegW-1:0] RegPc = 4'd15;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } tpps_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } tpps_cmd_t;

  typedef struct packed {
    logic last;
  } tpps_stat_t;

  function automatic logic [CountW-1:0] pop_count(input logic [ListW-1:0] v);
    logic [CountW-1:0] c;
    c = '0;
    for (int i = 0; i < ListW; i++) begin
      c = c + CountW'(v[i]);
    end
    return c;
  endfunction

  function automatic logic [SelW-1:0] low_index(input logic [ListW-1:0] v);
    logic [SelW-1:0] idx;
    idx = '0;
    for (int i = ListW - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SelW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [SelW-1:0] high_index(input logic [ListW-1:0] v);
    logic [SelW-1:0] idx;
    idx = '0;
    for (int i = 0; i < ListW; i++) begin
      if (v[i]) begin
        idx = SelW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- src/tpps_ctrl.sv -----
// Controller for the Thumb push/pop sequencer: idle/run state machine,
// busy flag and word strobe. Depends on tpps_pkg.
module tpps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tpps_pkg::tpps_stat_t stat,
  output tpps_pkg::tpps_cmd_t  cmd,
  output logic                busy,
  output logic                strobe
);

  tpps_pkg::tpps_state_t state;
  tpps_pkg::tpps_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tpps_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= cmd.step;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      tpps_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = tpps_pkg::ST_RUN;
        end
      end
      tpps_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_next = tpps_pkg::ST_IDLE;
        end
      end
      default: state_next = tpps_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != tpps_pkg::ST_IDLE);

`ifndef NO_ASSERTIONS
  a_load_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == tpps_pkg::ST_RUN))
    else $error("load did not enter run state");

  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    (state == tpps_pkg::ST_RUN) && stat.last |=> (state == tpps_pkg::ST_IDLE) && strobe)
    else $error("final word did not return controller to idle");

  a_strobe_from_run: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == tpps_pkg::ST_RUN))
    else $error("strobe outside run state");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load)
    else $error("load while busy");
`endif

endmodule

// ----- src/tpps_dp.sv -----
// Datapath for the Thumb push/pop sequencer: instruction registers, address
// walk, register selection and word output registers. Depends on tpps_pkg.
module tpps_dp (
  input  logic                             clk,
  input  tpps_pkg::tpps_cmd_t               cmd,
  input  logic                             mode,
  input  logic [tpps_pkg::ListW-1:0]       reg_list,
  input  logic                             link_or_pc,
  input  logic [tpps_pkg::AddrW-1:0]       stack_pointer,
  output tpps_pkg::tpps_stat_t              stat,
  output logic                             transfer_valid,
  output logic [tpps_pkg::AddrW-1:0]       bus_address,
  output logic                             is_store,
  output logic [tpps_pkg::RegW-1:0]        reg_index,
  output logic                             sequential,
  output logic [tpps_pkg::AddrW-1:0]       new_stack_pointer,
  output logic                             last
);

  logic                         op_pop;
  logic [tpps_pkg::ListW-1:0]   list_rem;
  logic [tpps_pkg::ListW-1:0]   list_rem_next;
  logic                         extra_rem;
  logic                         extra_rem_next;
  logic [tpps_pkg::AddrW-1:0]   addr;
  logic [tpps_pkg::AddrW-1:0]   addr_next;
  logic                         first;
  logic [tpps_pkg::AddrW-1:0]   nsp;

  logic [tpps_pkg::CountW-1:0]  count;
  logic [tpps_pkg::AddrW-1:0]   span;
  logic [tpps_pkg::SelW-1:0]    sel;
  logic                         w_valid;
  logic [tpps_pkg::AddrW-1:0]   w_addr;
  logic [tpps_pkg::RegW-1:0]    w_reg;
  logic                         w_seq;

  assign count = tpps_pkg::pop_count(reg_list) + tpps_pkg::CountW'(link_or_pc);
  assign span  = {(tpps_pkg::AddrW - tpps_pkg::CountW - 2)'(0), count, 2'b00};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_pop    <= mode;
      list_rem  <= reg_list;
      extra_rem <= link_or_pc;
      addr      <= stack_pointer;
      first     <= 1'b1;
      nsp       <= mode ? stack_pointer + span : stack_pointer - span;
    end else if (cmd.step) begin
      list_rem  <= list_rem_next;
      extra_rem <= extra_rem_next;
      addr      <= addr_next;
      first     <= 1'b0;
    end
    if (cmd.step) begin
      transfer_valid    <= w_valid;
      bus_address       <= w_addr;
      is_store          <= w_valid & ~op_pop;
      reg_index         <= w_reg;
      sequential        <= w_seq;
      new_stack_pointer <= nsp;
      last              <= stat.last;
    end
  end

  always_comb begin
    sel            = op_pop ? tpps_pkg::low_index(list_rem) : tpps_pkg::high_index(list_rem);
    addr_next      = op_pop ? addr + tpps_pkg::WordBytes : addr - tpps_pkg::WordBytes;
    list_rem_next  = list_rem;
    extra_rem_next = extra_rem;
    w_valid        = 1'b1;
    w_addr         = op_pop ? addr : addr_next;
    w_reg          = {1'b0, sel};
    w_seq          = ~first;
    priority if (list_rem == '0 && !extra_rem) begin
      w_valid   = 1'b0;
      w_addr    = '0;
      w_reg     = '0;
      w_seq     = 1'b0;
      addr_next = addr;
    end else if (!op_pop && extra_rem) begin
      w_reg          = tpps_pkg::RegLr;
      extra_rem_next = 1'b0;
    end else if (list_rem != '0) begin
      list_rem_next = list_rem & ~(tpps_pkg::ListW'(1) << sel);
    end else begin
      w_reg          = tpps_pkg::RegPc;
      w_seq          = 1'b1;
      extra_rem_next = 1'b0;
    end
    stat.last = (list_rem_next == '0) && !extra_rem_next;
  end

`ifndef NO_ASSERTIONS
  a_list_shrinks: assert property (@(posedge clk)
    cmd.step && !stat.last |=> ($countones(list_rem) + 32'(extra_rem))
      == ($countones($past(list_rem)) + 32'($past(extra_rem)) - 1))
    else $error("step did not consume exactly one word");

  a_first_nonseq: assert property (@(posedge clk)
    cmd.step && first && w_valid && w_reg != tpps_pkg::RegPc |-> !w_seq)
    else $error("first word marked sequential");

  a_pc_last: assert property (@(posedge clk)
    cmd.step && w_reg == tpps_pkg::RegPc && w_valid |-> stat.last)
    else $error("PC load not final word");
`endif

endmodule

// ----- src/thumb_push_pop_sequencer_core.sv -----
// Thumb push/pop sequencer top level: joins controller and datapath.
// Flow: start is taken only in idle and loads the instruction registers; in run, each step
// registers one word onto the result ports and the controller registers the strobe for it.
// Each instruction strobes 1 to 9 words on the result ports, one word per cycle.
// Reset: synchronous rst clears the controller to idle and drops strobe; no clearing pass.
// Depends on tpps_pkg, tpps_ctrl, tpps_dp.
module thumb_push_pop_sequencer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic [tpps_pkg::ListW-1:0] reg_list,
  input  logic                       link_or_pc,
  input  logic [tpps_pkg::AddrW-1:0] stack_pointer,
  output logic                       strobe,
  output logic                       transfer_valid,
  output logic [tpps_pkg::AddrW-1:0] bus_address,
  output logic                       is_store,
  output logic [tpps_pkg::RegW-1:0]  reg_index,
  output logic                       sequential,
  output logic [tpps_pkg::AddrW-1:0] new_stack_pointer,
  output logic                       last
);

  tpps_pkg::tpps_cmd_t  cmd;
  tpps_pkg::tpps_stat_t stat;

  tpps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  tpps_dp u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .mode              (mode),
    .reg_list          (reg_list),
    .link_or_pc        (link_or_pc),
    .stack_pointer     (stack_pointer),
    .stat              (stat),
    .transfer_valid    (transfer_valid),
    .bus_address       (bus_address),
    .is_store          (is_store),
    .reg_index         (reg_index),
    .sequential        (sequential),
    .new_stack_pointer (new_stack_pointer),
    .last              (last)
  );

`ifndef NO_ASSERTIONS
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy after final word");

  a_start_strobe: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe ##1 strobe)
    else $error("first word not strobed two cycles after start");

  a_store_mode: assert property (@(posedge clk) disable iff (rst)
    strobe && is_store |-> transfer_valid)
    else $error("store flag on empty word");
`endif

endmodule

// ----- sim/tb_thumb_push_pop_sequencer_core.sv -----
// Self-checking testbench for thumb_push_pop_sequencer_core: a directed table, then random
// push/pop words with idle bursts, each word's transfers predicted and compared in order.
// Depends on tpps_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb_thumb_push_pop_sequencer_core;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP = 1'b1;
  localparam int RandWords = 164;
  localparam int CalmTail = 40;

  typedef struct packed {
    logic                       valid;
    logic [tpps_pkg::AddrW-1:0] addr;
    logic                       store;
    logic [tpps_pkg::RegW-1:0]  idx;
    logic                       seq;
    logic [tpps_pkg::AddrW-1:0] nsp;
    logic                       last;
  } xfer_t;

  typedef struct packed {
    logic                       m;
    logic [tpps_pkg::ListW-1:0] list;
    logic                       lp;
    logic [tpps_pkg::AddrW-1:0] sp;
    logic                       pinned;
    xfer_t                      res;
  } word_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       mode = MODE_PUSH;
  logic [tpps_pkg::ListW-1:0] reg_list = '0;
  logic                       link_or_pc = 1'b0;
  logic [tpps_pkg::AddrW-1:0] stack_pointer = '0;
  logic                       strobe;
  logic                       transfer_valid;
  logic [tpps_pkg::AddrW-1:0] bus_address;
  logic                       is_store;
  logic [tpps_pkg::RegW-1:0]  reg_index;
  logic                       sequential;
  logic [tpps_pkg::AddrW-1:0] new_stack_pointer;
  logic                       last;

  logic  pinned_valid = 1'b0;
  xfer_t pinned_xfer = '0;
  xfer_t pending_xfers[$];
  int    errors = 0;

  word_row_t directed_rows[16] = '{
    '{MODE_POP,  8'h00, 1'b0, 32'h1234_5678, 1'b1,
      '{1'b0, 32'h0000_0000, 1'b0, 4'd0, 1'b0, 32'h1234_5678, 1'b1}},
    '{MODE_PUSH, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 32'h0000_0000, 1'b0, 4'd0, 1'b0, 32'hFFFF_FFFF, 1'b1}},
    '{MODE_PUSH, 8'h00, 1'b1, 32'h0000_0000, 1'b1,
      '{1'b1, 32'hFFFF_FFFC, 1'b1, tpps_pkg::RegLr, 1'b0, 32'hFFFF_FFFC, 1'b1}},
    '{MODE_POP,  8'h00, 1'b1, 32'hFFFF_FFFC, 1'b1,
      '{1'b1, 32'hFFFF_FFFC, 1'b0, tpps_pkg::RegPc, 1'b1, 32'h0000_0000, 1'b1}},
    '{MODE_PUSH, 8'h01, 1'b0, 32'h0000_1000, 1'b1,
      '{1'b1, 32'h0000_0FFC, 1'b1, 4'd0, 1'b0, 32'h0000_0FFC, 1'b1}},
    '{MODE_POP,  8'h80, 1'b0, 32'h0000_2000, 1'b1,
      '{1'b1, 32'h0000_2000, 1'b0, 4'd7, 1'b0, 32'h0000_2004, 1'b1}},
    '{MODE_PUSH, 8'hFF, 1'b1, 32'h8000_0000, 1'b0, '0},
    '{MODE_POP,  8'hFF, 1'b1, 32'hFFFF_FFF0, 1'b0, '0},
    '{MODE_PUSH, 8'hFF, 1'b0, 32'h0000_0010, 1'b0, '0},
    '{MODE_POP,  8'hFF, 1'b0, 32'hAAAA_AAA8, 1'b0, '0},
    '{MODE_PUSH, 8'h55, 1'b1, 32'h5555_5554, 1'b0, '0},
    '{MODE_POP,  8'hAA, 1'b1, 32'h0000_0004, 1'b0, '0},
    '{MODE_PUSH, 8'h80, 1'b1, 32'hFFFF_FFFF, 1'b0, '0},
    '{MODE_POP,  8'h01, 1'b1, 32'h0000_0003, 1'b0, '0},
    '{MODE_PUSH, 8'h81, 1'b0, 32'h0000_0008, 1'b0, '0},
    '{MODE_POP,  8'h7E, 1'b0, 32'h7FFF_FFFC, 1'b0, '0}
  };

  thumb_push_pop_sequencer_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .reg_list         (reg_list),
    .link_or_pc       (link_or_pc),
    .stack_pointer    (stack_pointer),
    .strobe           (strobe),
    .transfer_valid   (transfer_valid),
    .bus_address      (bus_address),
    .is_store         (is_store),
    .reg_index        (reg_index),
    .sequential       (sequential),
    .new_stack_pointer(new_stack_pointer),
    .last             (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void expand_transfers(input logic m,
                                           input logic [tpps_pkg::ListW-1:0] list,
                                           input logic lp,
                                           input logic [tpps_pkg::AddrW-1:0] sp);
    logic [tpps_pkg::CountW-1:0] n;
    logic [tpps_pkg::AddrW-1:0]  nsp;
    logic [tpps_pkg::AddrW-1:0]  addr;
    int                          base;
    n = tpps_pkg::CountW'(lp);
    for (int i = 0; i < tpps_pkg::ListW; i++) begin
      n = n + tpps_pkg::CountW'(list[i]);
    end
    if (n == 0) begin
      pending_xfers.push_back('{1'b0, '0, 1'b0, '0, 1'b0, sp, 1'b1});
      return;
    end
    base = pending_xfers.size();
    addr = sp;
    if (m == MODE_PUSH) begin
      nsp = sp - tpps_pkg::AddrW'(n) * tpps_pkg::WordBytes;
      if (lp) begin
        addr = addr - tpps_pkg::WordBytes;
        pending_xfers.push_back('{1'b1, addr, 1'b1, tpps_pkg::RegLr, 1'b0, nsp, 1'b0});
      end
      for (int i = tpps_pkg::ListW - 1; i >= 0; i--) begin
        if (list[i]) begin
          addr = addr - tpps_pkg::WordBytes;
          pending_xfers.push_back('{1'b1, addr, 1'b1, tpps_pkg::RegW'(i),
                                   pending_xfers.size() != base, nsp, 1'b0});
        end
      end
    end else begin
      nsp = sp + tpps_pkg::AddrW'(n) * tpps_pkg::WordBytes;
      for (int i = 0; i < tpps_pkg::ListW; i++) begin
        if (list[i]) begin
          pending_xfers.push_back('{1'b1, addr, 1'b0, tpps_pkg::RegW'(i),
                                   pending_xfers.size() != base, nsp, 1'b0});
          addr = addr + tpps_pkg::WordBytes;
        end
      end
      // PC load is always sequential
      if (lp) begin
        pending_xfers.push_back('{1'b1, addr, 1'b0, tpps_pkg::RegPc, 1'b1, nsp, 1'b0});
      end
    end
    pending_xfers[pending_xfers.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [tpps_pkg::AddrW-1:0] want,
                                      input logic [tpps_pkg::AddrW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    xfer_t want;
    if (!rst && start && !busy) begin
      if (pinned_valid) begin
        pending_xfers.push_back(pinned_xfer);
      end else begin
        expand_transfers(mode, reg_list, link_or_pc, stack_pointer);
      end
    end
    if (!rst && strobe) begin
      if (pending_xfers.size() == 0) begin
        $display("%0t: strobe with nothing expected, expected none got %h", $time, bus_address);
        errors++;
      end else begin
        want = pending_xfers.pop_front();
        check_field("transfer_valid", tpps_pkg::AddrW'(want.valid),
                    tpps_pkg::AddrW'(transfer_valid));
        check_field("bus_address", want.addr, bus_address);
        check_field("is_store", tpps_pkg::AddrW'(want.store), tpps_pkg::AddrW'(is_store));
        check_field("reg_index", tpps_pkg::AddrW'(want.idx), tpps_pkg::AddrW'(reg_index));
        check_field("sequential", tpps_pkg::AddrW'(want.seq), tpps_pkg::AddrW'(sequential));
        check_field("new_stack_pointer", want.nsp, new_stack_pointer);
        check_field("last", tpps_pkg::AddrW'(want.last), tpps_pkg::AddrW'(last));
      end
    end
  end

  task automatic send_word(input word_row_t r);
    mode <= r.m;
    reg_list <= r.list;
    link_or_pc <= r.lp;
    stack_pointer <= r.sp;
    pinned_valid <= r.pinned;
    pinned_xfer <= r.res;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    word_row_t r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[k]) begin
      send_word(directed_rows[k]);
    end
    for (int k = 0; k < RandWords; k++) begin
      r = '0;
      r.m = 1'($urandom_range(0, 1));
      r.lp = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: r.list = 8'h00;
        1: r.list = 8'hFF;
        2: r.list = 8'h01 << $urandom_range(0, 7);
        default: r.list = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: r.sp = $urandom;
        1: r.sp = $urandom_range(0, 64);
        2: r.sp = 32'hFFFF_FFFF - $urandom_range(0, 64);
        default: r.sp = $urandom & 32'hFFFF_FFFC;
      endcase
      send_word(r);
      if (k == RandWords / 2) begin
        // drain everything before carrying on
        start <= 1'b0;
        do @(posedge clk); while (pending_xfers.size() != 0);
      end else if (k < RandWords - CalmTail && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
    start <= 1'b0;
    do @(posedge clk); while (pending_xfers.size() != 0);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
